>>> src/bplr_pkg.sv
// Shared types, constants and helpers for the long-press and repeat detector.
package bplr_pkg;

    // Field widths
    localparam int ADDR_W = 48;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int STAT_W = 8;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Defaults
    localparam int              DEF_TABLE_DEPTH    = 8;
    localparam logic [CFG_W-1:0] INITIAL_WAIT_RST   = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

    // Register indexes
    localparam logic REG_INITIAL_WAIT    = 1'b0;
    localparam logic REG_REPEAT_INTERVAL = 1'b1;

    // Status byte masks
    localparam logic [STAT_W-1:0] STATUS_B1   = 8'h10;
    localparam logic [STAT_W-1:0] STATUS_B0   = 8'h08;
    localparam logic [STAT_W-1:0] STATUS_A1   = 8'h04;
    localparam logic [STAT_W-1:0] STATUS_PUSH = 8'h01;

    // Action codes
    localparam logic ACT_TELEGRAM = 1'b0;
    localparam logic ACT_TICK     = 1'b1;

    // Event kinds
    localparam logic [1:0] EV_PUSHED = 2'd0;
    localparam logic [1:0] EV_SHORT  = 2'd1;
    localparam logic [1:0] EV_LONG   = 2'd2;
    localparam logic [1:0] EV_REPEAT = 2'd3;

    // Button codes
    localparam logic [1:0] BTN_A0 = 2'd0;
    localparam logic [1:0] BTN_A1 = 2'd1;
    localparam logic [1:0] BTN_B0 = 2'd2;
    localparam logic [1:0] BTN_B1 = 2'd3;

    // One held-table entry as stored in RAM
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [1:0]        button;
        logic [TIME_W-1:0] start;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic idx_clear;
        logic idx_inc;
        logic chk_tel;
        logic chk_rep;
        logic fin_tel;
        logic flush;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic item_tick;
        logic tick_scan;
        logic is_tick;
        logic hit;
        logic qualify;
        logic idx_last;
        logic pend_valid;
        logic out_free;
    } stat_t;

    // Configuration write from the bus decode
    typedef struct packed {
        logic             we;
        logic             sel;
        logic [CFG_W-1:0] data;
    } cfg_wr_t;

    // Priority decode: B1, B0, A1, else A0
    function automatic logic [1:0] decode_button(input logic [STAT_W-1:0] status);
        logic [1:0] btn;
        if ((status & STATUS_B1) != '0)
            btn = BTN_B1;
        else if ((status & STATUS_B0) != '0)
            btn = BTN_B0;
        else if ((status & STATUS_A1) != '0)
            btn = BTN_A1;
        else
            btn = BTN_A0;
        return btn;
    endfunction

endpackage

>>> src/bplr_in_if.sv
// Input channel: switch telegrams and millisecond ticks.
interface bplr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [bplr_pkg::ADDR_W-1:0] device_address;
    logic [bplr_pkg::STAT_W-1:0] switch_status;

    modport source (output valid, action, device_address, switch_status, input ready);
    modport sink   (input valid, action, device_address, switch_status, output ready);
endinterface

>>> src/bplr_out_if.sv
// Output channel: button events.
interface bplr_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  event_kind;
    logic [1:0]                  button;
    logic [bplr_pkg::ADDR_W-1:0] event_address;
    logic                        table_full;
    logic                        last;

    modport source (output valid, event_kind, button, event_address, table_full, last,
                    input ready);
    modport sink   (input valid, event_kind, button, event_address, table_full, last,
                    output ready);
endinterface

>>> src/bplr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bplr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/bplr_ctrl.sv
// Controller state machine: sequences table scans and result hand-off.
module bplr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bplr_pkg::stat_t stat,
    output bplr_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RD    = 5'b00010,
        ST_CHK   = 5'b00100,
        ST_FIN   = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rep_go;

    // Emitting a held repeat needs the output register
    assign rep_go = !(stat.qualify && stat.pend_valid) || stat.out_free;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!stat.item_tick || stat.tick_scan)
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (!stat.is_tick)
                begin
                    cmd.chk_tel = 1'b1;
                    if (stat.hit || stat.idx_last)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_RD;
                    end
                end
                else if (rep_go)
                begin
                    cmd.chk_rep = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin_tel = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/bplr_dp.sv
// Datapath: time base, held table, entry checks and output register.
module bplr_dp #(
    parameter int TABLE_DEPTH = bplr_pkg::DEF_TABLE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bplr_pkg::cmd_t              cmd,
    output bplr_pkg::stat_t             stat,
    input  bplr_pkg::cfg_wr_t           cfg_wr,
    output logic [bplr_pkg::CFG_W-1:0]  initial_wait_ms,
    output logic [bplr_pkg::CFG_W-1:0]  repeat_interval_ms,
    input  logic                        in_action,
    input  logic [bplr_pkg::ADDR_W-1:0] in_address,
    input  logic [bplr_pkg::STAT_W-1:0] in_status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  out_kind,
    output logic [1:0]                  out_button,
    output logic [bplr_pkg::ADDR_W-1:0] out_address,
    output logic                        out_full,
    output logic                        out_last
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W = $bits(bplr_pkg::entry_t);

    // Configuration and time base
    logic [bplr_pkg::CFG_W-1:0]  wait_reg;
    logic [bplr_pkg::CFG_W-1:0]  interval_reg;
    logic [bplr_pkg::TIME_W-1:0] now_reg;
    logic [bplr_pkg::CFG_W-1:0]  count_reg;
    logic [bplr_pkg::CFG_W-1:0]  count_inc;
    logic [bplr_pkg::CFG_W-1:0]  limit;
    logic                        tick_scan;

    // Latched item
    logic                        act_reg;
    logic [bplr_pkg::ADDR_W-1:0] addr_reg;
    logic [bplr_pkg::STAT_W-1:0] status_reg;

    // Scan state
    logic [TABLE_DEPTH-1:0]      valid_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            slot_reg;
    logic                        slot_ok_reg;
    logic                        match_reg;
    logic [bplr_pkg::TIME_W-1:0] start_reg;
    logic                        pend_valid_reg;
    logic [1:0]                  pend_button_reg;
    logic [bplr_pkg::ADDR_W-1:0] pend_addr_reg;

    // RAM
    logic                        ram_we;
    bplr_pkg::entry_t            ram_wentry;
    logic [ENTRY_W-1:0]          ram_rdata;
    bplr_pkg::entry_t            rentry;

    // Output register
    logic                        out_valid_reg;
    logic [1:0]                  out_kind_reg;
    logic [1:0]                  out_button_reg;
    logic [bplr_pkg::ADDR_W-1:0] out_addr_reg;
    logic                        out_full_reg;
    logic                        out_last_reg;
    logic                        out_load;
    logic [1:0]                  out_kind_next;
    logic [1:0]                  out_button_next;
    logic [bplr_pkg::ADDR_W-1:0] out_addr_next;
    logic                        out_full_next;
    logic                        out_last_next;

    // Entry checks
    logic                        cur_valid;
    logic                        hit;
    logic                        qualify;
    logic [bplr_pkg::TIME_W-1:0] elapsed_chk;
    logic [bplr_pkg::TIME_W-1:0] elapsed_fin;
    logic                        is_long;
    logic [1:0]                  tel_button;
    logic                        tel_push;
    logic                        out_free;

    assign initial_wait_ms    = wait_reg;
    assign repeat_interval_ms = interval_reg;

    // Interval counter step; a zero interval scans on every tick
    assign count_inc = count_reg + 1'b1;
    assign limit     = (interval_reg == '0) ? bplr_pkg::CFG_W'(1) : interval_reg;
    assign tick_scan = (count_inc >= limit);

    // Entry under check
    assign rentry      = bplr_pkg::entry_t'(ram_rdata);
    assign cur_valid   = valid_reg[idx_reg];
    assign hit         = cur_valid && (rentry.address == addr_reg);
    assign elapsed_chk = now_reg - rentry.start;
    assign qualify     = act_reg && cur_valid
                         && (elapsed_chk > {{(bplr_pkg::TIME_W-bplr_pkg::CFG_W){1'b0}}, wait_reg});
    assign elapsed_fin = now_reg - start_reg;
    assign is_long     = (elapsed_fin >= {{(bplr_pkg::TIME_W-bplr_pkg::CFG_W){1'b0}}, wait_reg});
    assign tel_button  = bplr_pkg::decode_button(status_reg);
    assign tel_push    = ((status_reg & bplr_pkg::STATUS_PUSH) != '0);
    assign out_free    = !out_valid_reg || out_ready;

    // Status to controller
    always_comb
    begin
        stat            = '0;
        stat.item_tick  = (in_action == bplr_pkg::ACT_TICK);
        stat.tick_scan  = tick_scan;
        stat.is_tick    = (act_reg == bplr_pkg::ACT_TICK);
        stat.hit        = hit;
        stat.qualify    = qualify;
        stat.idx_last   = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    // Table write on a tracked push
    assign ram_we             = cmd.fin_tel && tel_push && slot_ok_reg;
    assign ram_wentry.address = addr_reg;
    assign ram_wentry.button  = tel_button;
    assign ram_wentry.start   = now_reg;

    bplr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wentry),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Select the word to load into the output register
    always_comb
    begin
        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_button_next = out_button_reg;
        out_addr_next   = out_addr_reg;
        out_full_next   = out_full_reg;
        out_last_next   = out_last_reg;
        if (cmd.fin_tel)
        begin
            out_load        = 1'b1;
            out_button_next = tel_button;
            out_addr_next   = addr_reg;
            out_last_next   = 1'b1;
            if (tel_push)
            begin
                out_kind_next = bplr_pkg::EV_PUSHED;
                out_full_next = !slot_ok_reg;
            end
            else
            begin
                out_kind_next = (match_reg && is_long) ? bplr_pkg::EV_LONG : bplr_pkg::EV_SHORT;
                out_full_next = 1'b0;
            end
        end
        else if ((cmd.chk_rep && qualify && pend_valid_reg) || cmd.flush)
        begin
            out_load        = 1'b1;
            out_kind_next   = bplr_pkg::EV_REPEAT;
            out_button_next = pend_button_reg;
            out_addr_next   = pend_addr_reg;
            out_full_next   = 1'b0;
            out_last_next   = cmd.flush;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg       <= bplr_pkg::INITIAL_WAIT_RST;
            interval_reg   <= bplr_pkg::REPEAT_INTERVAL_RST;
            now_reg        <= '0;
            count_reg      <= '0;
            valid_reg      <= '0;
            idx_reg        <= '0;
            slot_ok_reg    <= 1'b0;
            match_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            act_reg        <= bplr_pkg::ACT_TELEGRAM;
        end
        else
        begin
            // Configuration writes
            if (cfg_wr.we && cfg_wr.sel == bplr_pkg::REG_INITIAL_WAIT)
            begin
                wait_reg <= cfg_wr.data;
            end
            if (cfg_wr.we && cfg_wr.sel == bplr_pkg::REG_REPEAT_INTERVAL)
            begin
                interval_reg <= cfg_wr.data;
            end

            // Accept an item; a tick advances time first
            if (cmd.accept)
            begin
                act_reg        <= in_action;
                slot_ok_reg    <= 1'b0;
                match_reg      <= 1'b0;
                pend_valid_reg <= 1'b0;
                if (in_action == bplr_pkg::ACT_TICK)
                begin
                    now_reg   <= now_reg + 1'b1;
                    count_reg <= tick_scan ? '0 : count_inc;
                end
            end

            // Advance the scan index
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            // Telegram check: a match wins over the first free slot
            if (cmd.chk_tel)
            begin
                if (hit)
                begin
                    match_reg   <= 1'b1;
                    slot_ok_reg <= 1'b1;
                end
                else if (!slot_ok_reg && !cur_valid)
                begin
                    slot_ok_reg <= 1'b1;
                end
            end

            // Hold a qualifying repeat until the next one or the end
            if (cmd.chk_rep && qualify)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            // Update the held flags
            if (cmd.fin_tel && slot_ok_reg)
            begin
                if (tel_push)
                begin
                    valid_reg[slot_reg] <= 1'b1;
                end
                else if (match_reg)
                begin
                    valid_reg[slot_reg] <= 1'b0;
                end
            end

            // Output word valid
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg   <= in_address;
            status_reg <= in_status;
        end
        if (cmd.chk_tel && (hit || (!slot_ok_reg && !cur_valid)))
        begin
            slot_reg <= idx_reg;
        end
        if (cmd.chk_tel && hit)
        begin
            start_reg <= rentry.start;
        end
        if (cmd.chk_rep && qualify)
        begin
            pend_button_reg <= rentry.button;
            pend_addr_reg   <= rentry.address;
        end
        if (out_load)
        begin
            out_kind_reg   <= out_kind_next;
            out_button_reg <= out_button_next;
            out_addr_reg   <= out_addr_next;
            out_full_reg   <= out_full_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_button  = out_button_reg;
    assign out_address = out_addr_reg;
    assign out_full    = out_full_reg;
    assign out_last    = out_last_reg;

endmodule

>>> src/button_press_long_release_repeat.sv
// Top level of the long-press and auto-repeat detector.
//
//   channel    | direction | handshake        | word
//   item_in    | in        | valid/ready      | action, device_address, switch_status
//   event_out  | out       | valid/ready      | event_kind, button, event_address,
//              |           |                  | table_full, last
//   apb        | in        | psel/penable     | two 16-bit registers at 0x0 and 0x4
//
// A telegram searches the held table, which sits in a RAM with one read port: each
// entry is read in ST_RD and checked in ST_CHK, and the search stops on an address
// match. A tick without a scan is taken in ST_IDLE alone; a scanning tick reads every
// entry and ends in ST_FLUSH. A stalled output holds the scan while a repeat word waits.
// Reset clears time, interval count and all held flags; there is no clearing pass.
module button_press_long_release_repeat #(
    parameter int TABLE_DEPTH = bplr_pkg::DEF_TABLE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bplr_in_if.sink                      item_in,
    bplr_out_if.source                   event_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bplr_pkg::APB_AW-1:0]  paddr,
    input  logic [bplr_pkg::APB_DW-1:0]  pwdata,
    output logic [bplr_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    bplr_pkg::cmd_t             cmd;
    bplr_pkg::stat_t            stat;
    bplr_pkg::cfg_wr_t          cfg_wr;
    logic [bplr_pkg::CFG_W-1:0] initial_wait_ms;
    logic [bplr_pkg::CFG_W-1:0] repeat_interval_ms;

    // Decode register writes
    assign pready      = 1'b1;
    assign cfg_wr.we   = psel && penable && pwrite && pready;
    assign cfg_wr.sel  = paddr[2];
    assign cfg_wr.data = pwdata[bplr_pkg::CFG_W-1:0];

    // Read back
    always_comb
    begin
        case (paddr[2])
            bplr_pkg::REG_INITIAL_WAIT:
                prdata = bplr_pkg::APB_DW'(initial_wait_ms);
            bplr_pkg::REG_REPEAT_INTERVAL:
                prdata = bplr_pkg::APB_DW'(repeat_interval_ms);
            default:
                prdata = '0;
        endcase
    end

    bplr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (item_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bplr_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_wr             (cfg_wr),
        .initial_wait_ms    (initial_wait_ms),
        .repeat_interval_ms (repeat_interval_ms),
        .in_action          (item_in.action),
        .in_address         (item_in.device_address),
        .in_status          (item_in.switch_status),
        .out_valid          (event_out.valid),
        .out_ready          (event_out.ready),
        .out_kind           (event_out.event_kind),
        .out_button         (event_out.button),
        .out_address        (event_out.event_address),
        .out_full           (event_out.table_full),
        .out_last           (event_out.last)
    );

endmodule

>>> verif/tb_bplr_press_tracker_pkg.sv
// Press tracker that predicts and checks the event words of the long-press and repeat detector.
package press_tracker_pkg;
    import bplr_pkg::*;

    localparam int TRACK_DEPTH = DEF_TABLE_DEPTH;

    // One event word as seen on the output channel
    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        button;
        logic [ADDR_W-1:0] address;
        logic              full;
        logic              last;
    } event_word_t;

    class press_tracker;
        logic [CFG_W-1:0]  wait_ms;
        logic [CFG_W-1:0]  interval_ms;
        logic [TIME_W-1:0] now_ms;
        logic [CFG_W-1:0]  interval_count;
        bit                held_valid[TRACK_DEPTH];
        logic [ADDR_W-1:0] held_address[TRACK_DEPTH];
        logic [1:0]        held_button[TRACK_DEPTH];
        logic [TIME_W-1:0] held_start[TRACK_DEPTH];
        event_word_t       expected_events[$];

        int errors;
        int checked;
        int items;
        int telegrams;
        int ticks;
        int long_releases;
        int repeats;
        int untracked;
        int most_words;

        function new();
            wait_ms        = INITIAL_WAIT_RST;
            interval_ms    = REPEAT_INTERVAL_RST;
            now_ms         = '0;
            interval_count = '0;
            foreach (held_valid[i])
                held_valid[i] = 1'b0;
        endfunction

        function void set_register(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_INITIAL_WAIT)
                wait_ms = value;
            else
                interval_ms = value;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        // Priority B1, B0, A1, else A0
        function logic [1:0] button_of(logic [STAT_W-1:0] status);
            if ((status & STATUS_B1) != '0)
                return BTN_B1;
            if ((status & STATUS_B0) != '0)
                return BTN_B0;
            if ((status & STATUS_A1) != '0)
                return BTN_A1;
            return BTN_A0;
        endfunction

        // Advance the held table for one accepted word and queue the events it causes
        function void note_item(logic action, logic [ADDR_W-1:0] addr,
                                logic [STAT_W-1:0] status);
            int                slot;
            int                queued_before;
            logic [TIME_W-1:0] elapsed;
            logic [CFG_W-1:0]  scan_every;
            event_word_t       w;

            queued_before = expected_events.size();
            items++;
            if (action == ACT_TELEGRAM)
            begin
                telegrams++;
                slot = -1;
                for (int i = 0; i < TRACK_DEPTH; i++)
                    if (slot < 0 && held_valid[i] && held_address[i] == addr)
                        slot = i;
                w.button  = button_of(status);
                w.address = addr;
                w.full    = 1'b0;
                w.last    = 1'b1;
                if ((status & STATUS_PUSH) != '0)
                begin
                    w.kind = EV_PUSHED;
                    // a new address takes the lowest free slot
                    for (int i = 0; i < TRACK_DEPTH; i++)
                        if (slot < 0 && !held_valid[i])
                            slot = i;
                    if (slot < 0)
                    begin
                        w.full = 1'b1;
                        untracked++;
                    end
                    else
                    begin
                        held_valid[slot]   = 1'b1;
                        held_address[slot] = addr;
                        held_button[slot]  = w.button;
                        held_start[slot]   = now_ms;
                    end
                end
                else
                begin
                    w.kind = EV_SHORT;
                    if (slot >= 0)
                    begin
                        elapsed = now_ms - held_start[slot];
                        if (elapsed >= TIME_W'(wait_ms))
                        begin
                            w.kind = EV_LONG;
                            long_releases++;
                        end
                        held_valid[slot] = 1'b0;
                    end
                end
                expected_events = {expected_events, w};
            end
            else
            begin
                ticks++;
                scan_every = (interval_ms == '0) ? CFG_W'(1) : interval_ms;
                now_ms = now_ms + 1;
                interval_count = interval_count + 1;
                if (interval_count >= scan_every)
                begin
                    interval_count = '0;
                    for (int i = 0; i < TRACK_DEPTH; i++)
                    begin
                        elapsed = now_ms - held_start[i];
                        if (held_valid[i] && elapsed > TIME_W'(wait_ms))
                        begin
                            w.kind    = EV_REPEAT;
                            w.button  = held_button[i];
                            w.address = held_address[i];
                            w.full    = 1'b0;
                            w.last    = 1'b0;
                            expected_events = {expected_events, w};
                            repeats++;
                        end
                    end
                    if (expected_events.size() > queued_before)
                        expected_events[expected_events.size() - 1].last = 1'b1;
                end
            end
            if (expected_events.size() - queued_before > most_words)
                most_words = expected_events.size() - queued_before;
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        // Compare one output word against the oldest expected word
        task check_event(event_word_t got);
            event_word_t want;
            if (expected_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word kind %0d button %0d addr %h",
                                          got.kind, got.button, got.address));
            end
            else
            begin
                want = expected_events.pop_front();
                checked++;
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("word %0d event_kind %0d, want %0d",
                                              checked, got.kind, want.kind));
                if (got.button !== want.button)
                    report_mismatch($sformatf("word %0d button %0d, want %0d",
                                              checked, got.button, want.button));
                if (got.address !== want.address)
                    report_mismatch($sformatf("word %0d event_address %h, want %h",
                                              checked, got.address, want.address));
                if (got.full !== want.full)
                    report_mismatch($sformatf("word %0d table_full %0b, want %0b",
                                              checked, got.full, want.full));
                if (got.last !== want.last)
                    report_mismatch($sformatf("word %0d last %0b, want %0b",
                                              checked, got.last, want.last));
            end
        endtask
    endclass

endpackage

>>> verif/tb_button_press_long_release_repeat.sv
// Testbench top for the long-press and repeat detector: stimulus, bus access and checking.
module tb_button_press_long_release_repeat;
    timeunit 1ns;
    timeprecision 1ps;

    import bplr_pkg::*;
    import press_tracker_pkg::*;

    localparam int DEPTH           = DEF_TABLE_DEPTH;
    localparam int DRAIN_CYCLES    = 2 * DEPTH + 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int POOL_SIZE       = 10;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bplr_in_if  item_ch ();
    bplr_out_if event_ch ();

    press_tracker      tracker;
    bit                calm;
    bit                hold_off_req;
    int                idle_cycles;
    int                reg_writes;
    logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

    button_press_long_release_repeat #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_ch),
        .event_out (event_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none in a calm phase
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [APB_AW-1:0] reg_addr(logic idx);
        return APB_AW'({idx, 2'b00});
    endfunction

    // Note accepted input words and check accepted output words
    always @(posedge clk)
    begin
        event_word_t got;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                tracker.note_item(item_ch.action, item_ch.device_address,
                                  item_ch.switch_status);
            if (event_ch.valid && event_ch.ready)
            begin
                got.kind    = event_ch.event_kind;
                got.button  = event_ch.button;
                got.address = event_ch.event_address;
                got.full    = event_ch.table_full;
                got.last    = event_ch.last;
                tracker.check_event(got);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (event_ch.valid && event_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("tb_button_press_long_release_repeat failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        event_ch.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                event_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                event_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                event_ch.ready <= 1'b1;
                stall_left = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
            end
        end
    end

    // Offer one word after a random gap and hold it until accepted
    task automatic send_item(logic action, logic [ADDR_W-1:0] addr, logic [STAT_W-1:0] status);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.action         <= action;
        item_ch.device_address <= addr;
        item_ch.switch_status  <= status;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, ADDR_W'({$urandom(), $urandom()}), STAT_W'($urandom_range(0, 255)));
    endtask

    // Read a register and compare it with what it should hold
    task automatic check_register(logic idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== APB_DW'(value))
            tracker.report_mismatch($sformatf("register %0d reads %h, want %h",
                                              idx, prdata, value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_register(logic idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
        reg_writes++;
        check_register(idx, value);
    endtask

    // Drop valid, wait for every expected word, then let a scan finish
    task automatic await_idle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] hold_ms, logic [CFG_W-1:0] every_ms);
        await_idle();
        write_register(REG_INITIAL_WAIT, hold_ms);
        write_register(REG_REPEAT_INTERVAL, every_ms);
    endtask

    // Edge cases: every button, held overwrite, full table, unknown release, zero settings
    task automatic run_directed();
        send_item(ACT_TELEGRAM, 48'h0, STATUS_PUSH);
        send_item(ACT_TELEGRAM, '1, STATUS_A1 | STATUS_PUSH);
        send_item(ACT_TELEGRAM, 48'h0000_0000_0002, STATUS_B0 | STATUS_PUSH);
        send_item(ACT_TELEGRAM, 48'h8000_0000_0003, STATUS_B1 | STATUS_PUSH);
        send_item(ACT_TELEGRAM, 48'h5555_AAAA_0004, 8'hFF);
        send_item(ACT_TELEGRAM, 48'h0, STATUS_B0 | STATUS_PUSH);
        send_item(ACT_TELEGRAM, 48'hAAAA_5555_0005, STATUS_PUSH);
        send_item(ACT_TELEGRAM, 48'h1234_5678_0006, STATUS_A1 | STATUS_PUSH);
        send_item(ACT_TELEGRAM, 48'hFEDC_BA98_0007, STATUS_B1 | STATUS_PUSH);
        send_item(ACT_TELEGRAM, 48'h0F0F_F0F0_0008, STATUS_PUSH);
        send_item(ACT_TELEGRAM, 48'h0000_0000_0002, STATUS_A1 | STATUS_PUSH);
        send_item(ACT_TELEGRAM, 48'h0F0F_F0F0_0008, 8'h00);
        send_item(ACT_TELEGRAM, 48'h0, 8'hFE);
        send_tick();

        // scan on every tick, short wait: repeats and a long release
        apply_settings(16'd1, 16'd1);
        send_tick();
        send_tick();
        send_item(ACT_TELEGRAM, 48'h8000_0000_0003, STATUS_B1);

        // zero settings act as a one-tick scan and a zero wait
        apply_settings(16'd0, 16'd0);
        send_item(ACT_TELEGRAM, 48'h0F0F_F0F0_0008, STATUS_B0 | STATUS_PUSH);
        send_item(ACT_TELEGRAM, 48'h0F0F_F0F0_0008, STATUS_B0);
        send_item(ACT_TELEGRAM, 48'h8000_0000_0003, STATUS_PUSH);
        send_tick();
        send_item(ACT_TELEGRAM, 48'h8000_0000_0003, 8'h00);
    endtask

    // Pushes and releases from a small address pool mixed with bursts of ticks
    task automatic run_random(int count);
        int                sent;
        int                r;
        int                burst;
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] addr;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                burst = $urandom_range(1, 8);
                repeat (burst) send_tick();
                sent += burst;
            end
            else
            begin
                status = STAT_W'($urandom_range(0, 255));
                status[0] = (r < 70);
                if (r % 12 == 0)
                    addr = ADDR_W'({$urandom(), $urandom()});
                else
                    addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_item(ACT_TELEGRAM, addr, status);
                sent++;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_TELEGRAM;
        item_ch.device_address = '0;
        item_ch.switch_status = '0;
        calm = 1'b0;
        hold_off_req = 1'b0;
        idle_cycles = 0;
        reg_writes = 0;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = ADDR_W'({$urandom(), $urandom()});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_register(REG_INITIAL_WAIT, INITIAL_WAIT_RST);
        check_register(REG_REPEAT_INTERVAL, REPEAT_INTERVAL_RST);
        run_directed();

        // receiver holds off long enough for the input to back up
        apply_settings(16'd4, 16'd2);
        hold_off_req = 1'b1;
        run_random(30);

        apply_settings(16'd1, 16'd1);
        calm = 1'b1;
        run_random(25);
        calm = 1'b0;

        apply_settings(16'd25, 16'd7);
        run_random(30);

        apply_settings(16'hFFFF, 16'hFFFF);
        run_random(15);

        apply_settings(16'd2, 16'd3);
        run_random(20);

        await_idle();
        if (tracker.pending() != 0)
            tracker.report_mismatch($sformatf("%0d expected words never arrived",
                                              tracker.pending()));
        $display("Run covered %0d input words (%0d telegrams, %0d ticks), %0d event words checked",
                 tracker.items, tracker.telegrams, tracker.ticks, tracker.checked);
        $display("with %0d long releases, %0d repeats, %0d full-table pushes, %0d register writes",
                 tracker.long_releases, tracker.repeats, tracker.untracked, reg_writes);
        if (tracker.errors == 0)
            $display("tb_button_press_long_release_repeat passed");
        else
            $display("tb_button_press_long_release_repeat failed");
        $finish;
    end

endmodule

>>> filelist.f
src/bplr_pkg.sv
src/bplr_in_if.sv
src/bplr_out_if.sv
src/bplr_ram.sv
src/bplr_ctrl.sv
src/bplr_dp.sv
src/button_press_long_release_repeat.sv
verif/tb_bplr_press_tracker_pkg.sv
verif/tb_button_press_long_release_repeat.sv
